// File: rtl/core/osm_pkg.sv
package osm_pkg;

    localparam int SLOT_COUNT     = 32;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int MODIFIER_SLOTS = 8;
    localparam int MATRIX_ROWS    = 4;
    localparam int MATRIX_COLS    = 16;
    localparam int POS_MASK_W     = 64;
    localparam int POS_IDX_W      = 6;

    localparam logic [SLOT_COUNT-1:0] MOD_MASK =
        SLOT_COUNT'((64'd1 << MODIFIER_SLOTS) - 64'd1);
    localparam logic [SLOT_COUNT-1:0] SLOT_ONE = SLOT_COUNT'(1);

    // apb register map, word index
    localparam int APB_ADDR_W = 4;
    localparam logic [1:0] REG_FIRST_SLOT = 2'd0;
    localparam logic [1:0] REG_LAST_SLOT  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [15:0] FIRST_SLOT_RST = 16'd0;
    localparam logic [15:0] LAST_SLOT_RST  = 16'd31;
    localparam logic [7:0]  TIMEOUT_RST    = 8'd40;

    typedef enum logic [1:0] {
        CMD_KEY         = 2'd0,
        CMD_TICK_BEFORE = 2'd1,
        CMD_TICK_AFTER  = 2'd2,
        CMD_CANCEL      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_PASS     = 2'd0,
        KIND_SUPPRESS = 2'd1,
        KIND_PRESS    = 2'd2,
        KIND_RELEASE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_TAIL
    } scan_state_t;

    typedef struct packed {
        logic [15:0] first_slot;
        logic [15:0] last_slot;
        logic [7:0]  timeout;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] latched;
        logic [SLOT_COUNT-1:0] sticky;
        logic [SLOT_COUNT-1:0] held;
        logic [POS_MASK_W-1:0] pos_mask;
        logic [7:0]            tick;
        logic [15:0]           prev_key;
        logic                  cancel_pending;
        logic                  cancel_sticky;
    } trk_t;

    // what one input leaves for the scan sequencer to emit
    typedef struct packed {
        logic [SLOT_COUNT-1:0] inj_mask;
        kind_t                 inj_kind;
        logic                  tail_valid;
        kind_t                 tail_kind;
        logic                  active;
    } plan_t;

endpackage

// File: rtl/core/one_shot_modifier_tracker_core.sv
// results: an item's results leave through a registered output, injected slots in rising
//   slot order and then any pass/suppress result; an output stall holds them back
// input: a new item is taken only once the scanner has loaded every result of the last
//   one into the output register; an item with no result leaves the scanner idle
// reset: aresetn is synchronous and active low; it clears all tracker state, the scan
//   sequencer and the output valid flag, and loads the config defaults 0, 31 and 40
module one_shot_modifier_tracker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [osm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_cmd,
    input  logic [15:0]                    s_key_code,
    input  logic [7:0]                     s_row,
    input  logic [7:0]                     s_col,
    input  logic                           s_now_down,
    input  logic                           s_was_down,
    input  logic                           s_injected,
    input  logic                           s_with_stickies,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [4:0]                     m_slot,
    output logic                           m_active,
    output logic                           m_last
);

    osm_pkg::cfg_t  cfg;
    osm_pkg::trk_t  trk_reg, trk_next;
    osm_pkg::plan_t plan;
    logic           scan_idle;
    logic           s_xfer;

    // input transfer only while the scanner has nothing left to emit
    assign s_ready = scan_idle;
    assign s_xfer  = s_valid && s_ready;

    osm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // whole state update for one input in one step; the scan only replays the slot mask
    osm_decide u_decide (
        .cfg           (cfg),
        .trk           (trk_reg),
        .cmd           (s_cmd),
        .key_code      (s_key_code),
        .row           (s_row),
        .col           (s_col),
        .now_down      (s_now_down),
        .was_down      (s_was_down),
        .injected      (s_injected),
        .with_stickies (s_with_stickies),
        .trk_next      (trk_next),
        .plan          (plan)
    );

    // tracker state: latched/sticky/held slots, position mask, timer, cancel flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_reg <= '0;
        end else if (s_xfer) begin
            trk_reg <= trk_next;
        end
    end

    // scanner: one mask slot a cycle, a stall holds set slots, then pass/suppress tail
    osm_slot_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_xfer),
        .plan     (plan),
        .idle     (scan_idle),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_slot   (m_slot),
        .m_active (m_active),
        .m_last   (m_last)
    );

endmodule

// File: rtl/core/osm_cfg_regs.sv
module osm_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [osm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output osm_pkg::cfg_t                    cfg
);

    osm_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[osm_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_slot <= osm_pkg::FIRST_SLOT_RST;
            cfg_reg.last_slot  <= osm_pkg::LAST_SLOT_RST;
            cfg_reg.timeout    <= osm_pkg::TIMEOUT_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                osm_pkg::REG_FIRST_SLOT: cfg_reg.first_slot <= pwdata[15:0];
                osm_pkg::REG_LAST_SLOT:  cfg_reg.last_slot  <= pwdata[15:0];
                osm_pkg::REG_TIMEOUT:    cfg_reg.timeout    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            osm_pkg::REG_FIRST_SLOT: prdata = {16'd0, cfg_reg.first_slot};
            osm_pkg::REG_LAST_SLOT:  prdata = {16'd0, cfg_reg.last_slot};
            osm_pkg::REG_TIMEOUT:    prdata = {24'd0, cfg_reg.timeout};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/core/osm_decide.sv
module osm_decide (
    input  osm_pkg::cfg_t  cfg,
    input  osm_pkg::trk_t  trk,
    input  logic [1:0]     cmd,
    input  logic [15:0]    key_code,
    input  logic [7:0]     row,
    input  logic [7:0]     col,
    input  logic           now_down,
    input  logic           was_down,
    input  logic           injected,
    input  logic           with_stickies,
    output osm_pkg::trk_t  trk_next,
    output osm_pkg::plan_t plan
);

    logic [15:0]                       diff;
    logic                              is_slot;
    logic [osm_pkg::SLOT_W-1:0]        idx;
    logic [osm_pkg::SLOT_COUNT-1:0]    sbit;
    logic                              pos_ok;
    logic [osm_pkg::POS_IDX_W-1:0]     pos_idx;
    logic [osm_pkg::POS_MASK_W-1:0]    pbit;
    logic                              on;
    logic                              off;
    logic [7:0]                        tick_inc;
    logic                              cp1;
    logic                              cst1;
    logic [osm_pkg::SLOT_COUNT-1:0]    clr_sticky;
    logic [osm_pkg::SLOT_COUNT-1:0]    rel;

    assign diff    = key_code - cfg.first_slot;
    assign is_slot = (key_code >= cfg.first_slot) && (key_code <= cfg.last_slot) &&
                     (diff < 16'(osm_pkg::SLOT_COUNT));
    assign idx     = diff[osm_pkg::SLOT_W-1:0];
    assign sbit    = osm_pkg::SLOT_ONE << idx;
    assign on      = now_down && !was_down;
    assign off     = was_down && !now_down;

    // position bit: column half picks the upper word, positions off the matrix give no bit
    assign pos_ok  = (row < 8'(osm_pkg::MATRIX_ROWS)) && (col < 8'(osm_pkg::MATRIX_COLS));
    assign pos_idx = {col >= 8'd8, row[1:0], col[2:0]};
    assign pbit    = pos_ok ? (osm_pkg::POS_MASK_W'(1) << pos_idx) : '0;

    // after-clear tick: timer step and timeout cancel
    assign tick_inc   = (trk.tick < cfg.timeout) ? trk.tick + 8'd1 : trk.tick;
    assign cp1        = trk.cancel_pending || (tick_inc >= cfg.timeout);
    assign cst1       = (tick_inc >= cfg.timeout) ? 1'b0 : trk.cancel_sticky;
    assign clr_sticky = cst1 ? trk.sticky : '0;
    assign rel        = ~trk.sticky & trk.latched & ~trk.held;

    always_comb begin
        trk_next        = trk;
        plan.inj_mask   = '0;
        plan.inj_kind   = osm_pkg::KIND_PRESS;
        plan.tail_valid = 1'b0;
        plan.tail_kind  = osm_pkg::KIND_PASS;

        unique case (osm_pkg::cmd_t'(cmd))
            osm_pkg::CMD_KEY: begin
                plan.tail_valid = 1'b1;
                if (injected) begin
                    plan.tail_kind = osm_pkg::KIND_PASS;
                end else if (trk.latched == '0) begin
                    if (!is_slot) begin
                        if ((trk.pos_mask & pbit) != '0) begin
                            if (off) begin
                                trk_next.pos_mask = trk.pos_mask & ~pbit;
                            end
                            plan.tail_kind = osm_pkg::KIND_SUPPRESS;
                        end
                    end else begin
                        if (off) begin
                            trk_next.held = trk.held & ~sbit;
                        end else if (on) begin
                            trk_next.tick     = 8'd0;
                            trk_next.held     = trk.held | sbit;
                            trk_next.latched  = trk.latched | sbit;
                            trk_next.prev_key = key_code;
                            plan.inj_mask     = sbit;
                        end
                        plan.tail_kind = osm_pkg::KIND_SUPPRESS;
                    end
                end else if (!now_down && !was_down) begin
                    plan.tail_kind = osm_pkg::KIND_PASS;
                end else if (is_slot) begin
                    plan.tail_kind = osm_pkg::KIND_SUPPRESS;
                    if ((trk.sticky & sbit) != '0) begin
                        if (on) begin
                            trk_next.prev_key = key_code;
                            trk_next.sticky   = trk.sticky & ~sbit;
                            trk_next.latched  = trk.latched & ~sbit;
                            plan.inj_mask     = sbit;
                            plan.inj_kind     = osm_pkg::KIND_RELEASE;
                        end
                    end else if (off) begin
                        trk_next.held = trk.held & ~sbit;
                        if (trk.tick >= cfg.timeout) begin
                            trk_next.latched = trk.latched & ~sbit;
                            plan.inj_mask    = sbit;
                            plan.inj_kind    = osm_pkg::KIND_RELEASE;
                        end
                    end else if (on) begin
                        trk_next.held = trk.held | sbit;
                        if (key_code == trk.prev_key) begin
                            trk_next.sticky = trk.sticky | sbit;
                        end else begin
                            trk_next.tick     = 8'd0;
                            trk_next.latched  = trk.latched | sbit;
                            trk_next.prev_key = key_code;
                            plan.inj_mask     = sbit;
                        end
                    end
                end else begin
                    plan.tail_kind = osm_pkg::KIND_PASS;
                    if (now_down) begin
                        trk_next.pos_mask       = trk.pos_mask | pbit;
                        trk_next.prev_key       = key_code;
                        trk_next.cancel_pending = 1'b1;
                    end
                end
            end
            osm_pkg::CMD_TICK_BEFORE: begin
                plan.inj_mask = trk.latched & osm_pkg::MOD_MASK;
            end
            osm_pkg::CMD_TICK_AFTER: begin
                if (trk.latched != '0) begin
                    trk_next.tick          = tick_inc;
                    trk_next.cancel_sticky = cst1;
                    if (cp1) begin
                        if ((clr_sticky != '0) || (rel != '0)) begin
                            trk_next.tick = 8'd0;
                        end
                        trk_next.sticky         = trk.sticky & ~clr_sticky;
                        trk_next.latched        = trk.latched & ~rel;
                        trk_next.cancel_pending = 1'b0;
                        trk_next.cancel_sticky  = 1'b0;
                        plan.inj_mask           = rel;
                        plan.inj_kind           = osm_pkg::KIND_RELEASE;
                    end
                end
            end
            osm_pkg::CMD_CANCEL: begin
                trk_next.cancel_pending = 1'b1;
                trk_next.cancel_sticky  = with_stickies;
            end
            default: ;
        endcase

        plan.active = (trk_next.latched != '0) && (trk_next.tick < cfg.timeout);
    end

endmodule

// File: rtl/core/osm_slot_scan.sv
module osm_slot_scan (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  osm_pkg::plan_t plan,
    output logic           idle,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_kind,
    output logic [4:0]     m_slot,
    output logic           m_active,
    output logic           m_last
);

    osm_pkg::scan_state_t           fsm_reg, fsm_next;
    logic [osm_pkg::SLOT_W-1:0]     idx_reg, idx_next;
    logic [osm_pkg::SLOT_COUNT-1:0] mask_reg, mask_next;
    logic                           tail_valid_reg;
    osm_pkg::kind_t                 inj_kind_reg;
    osm_pkg::kind_t                 tail_kind_reg;
    logic                           act_reg;
    logic                           m_valid_reg, m_valid_next;
    osm_pkg::kind_t                 m_kind_reg;
    logic [4:0]                     m_slot_reg;
    logic                           m_active_reg;
    logic                           m_last_reg;

    logic                           out_free;
    logic                           out_load;
    osm_pkg::kind_t                 load_kind;
    logic [4:0]                     load_slot;
    logic                           load_last;
    logic [osm_pkg::SLOT_COUNT-1:0] rest;

    assign out_free = !m_valid_reg || m_ready;
    assign rest     = mask_reg & ~(osm_pkg::SLOT_ONE << idx_reg);
    assign idle     = (fsm_reg == osm_pkg::SCAN_IDLE);

    always_comb begin
        fsm_next  = fsm_reg;
        idx_next  = idx_reg;
        mask_next = mask_reg;
        out_load  = 1'b0;
        load_kind = tail_kind_reg;
        load_slot = 5'd0;
        load_last = 1'b1;

        unique case (fsm_reg)
            osm_pkg::SCAN_IDLE: begin
                if (start) begin
                    mask_next = plan.inj_mask;
                    idx_next  = '0;
                    if (plan.inj_mask != '0) begin
                        fsm_next = osm_pkg::SCAN_RUN;
                    end else if (plan.tail_valid) begin
                        fsm_next = osm_pkg::SCAN_TAIL;
                    end
                end
            end
            osm_pkg::SCAN_RUN: begin
                if (mask_reg[idx_reg]) begin
                    load_kind = inj_kind_reg;
                    load_slot = 5'(idx_reg);
                    load_last = (rest == '0) && !tail_valid_reg;
                    if (out_free) begin
                        out_load  = 1'b1;
                        mask_next = rest;
                        idx_next  = idx_reg + osm_pkg::SLOT_W'(1);
                        if (rest == '0) begin
                            fsm_next = tail_valid_reg ? osm_pkg::SCAN_TAIL
                                                      : osm_pkg::SCAN_IDLE;
                        end
                    end
                end else begin
                    idx_next = idx_reg + osm_pkg::SLOT_W'(1);
                end
            end
            osm_pkg::SCAN_TAIL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    fsm_next = osm_pkg::SCAN_IDLE;
                end
            end
            default: fsm_next = osm_pkg::SCAN_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= osm_pkg::SCAN_IDLE;
            idx_reg        <= '0;
            mask_reg       <= '0;
            tail_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            idx_reg     <= idx_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
            if (start && idle) begin
                tail_valid_reg <= plan.tail_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && idle) begin
            inj_kind_reg  <= plan.inj_kind;
            tail_kind_reg <= plan.tail_kind;
            act_reg       <= plan.active;
        end
        if (out_load) begin
            m_kind_reg   <= load_kind;
            m_slot_reg   <= load_slot;
            m_active_reg <= act_reg;
            m_last_reg   <= load_last;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_slot   = m_slot_reg;
    assign m_active = m_active_reg;
    assign m_last   = m_last_reg;

endmodule

// File: rtl/core/osm_checker.sv
module osm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [4:0] m_slot,
    input logic       m_active,
    input logic       m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_slot) &&
            $stable(m_active) && $stable(m_last))
        else $error("result changed while stalled");

    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == 2'(osm_pkg::KIND_PASS) || m_kind == 2'(osm_pkg::KIND_SUPPRESS))
            |-> m_last && (m_slot == 5'd0))
        else $error("pass or suppress result is not the final one");

    a_busy_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready while an item still has results");

    // input only frees up once the final result has been loaded
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid || !s_ready)
        else $error("input ready after a non-final transfer without a final result");

endmodule

bind one_shot_modifier_tracker_core osm_checker u_osm_checker (.*);

// File: tb/tb_one_shot_modifier_tracker_core.sv
module tb_one_shot_modifier_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    // longest slot scan plus the scanner and output registers, with margin
    localparam int DRAIN_CYCLES = 40;
    // long receiver hold-off so the block backs up into its input
    localparam int STALL_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_REPORTS  = 10;
    // pool of keys the random part plays with: low half slot codes, high half plain keys
    localparam int POOL_KEYS    = 8;

    // one input transfer
    typedef struct packed {
        osm_pkg::cmd_t cmd;
        logic [15:0]   key_code;
        logic [7:0]    row;
        logic [7:0]    col;
        logic          now_down;
        logic          was_down;
        logic          injected;
        logic          with_stickies;
    } key_item_t;

    // one result transfer
    typedef struct packed {
        osm_pkg::kind_t             kind;
        logic [osm_pkg::SLOT_W-1:0] slot;
        logic                       active;
        logic                       is_last;
    } key_result_t;

    // clock, reset and every block input start at known values
    logic                           aclk            = 1'b0;
    logic                           aresetn         = 1'b0;
    logic                           psel            = 1'b0;
    logic                           penable         = 1'b0;
    logic                           pwrite          = 1'b0;
    logic [osm_pkg::APB_ADDR_W-1:0] paddr           = '0;
    logic [31:0]                    pwdata          = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_valid         = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_cmd           = '0;
    logic [15:0]                    s_key_code      = '0;
    logic [7:0]                     s_row           = '0;
    logic [7:0]                     s_col           = '0;
    logic                           s_now_down      = 1'b0;
    logic                           s_was_down      = 1'b0;
    logic                           s_injected      = 1'b0;
    logic                           s_with_stickies = 1'b0;
    logic                           m_valid;
    logic                           m_ready         = 1'b0;
    logic [1:0]                     m_kind;
    logic [4:0]                     m_slot;
    logic                           m_active;
    logic                           m_last;

    // idle percentages of both sides, changed between phases
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // hold-off request: a flip of stall_flip starts a stall of STALL_CYCLES
    bit stall_flip = 1'b0;
    bit stall_seen = 1'b0;
    int stall_left = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;

    // shadow of the configuration registers
    logic [15:0] cfg_first   = osm_pkg::FIRST_SLOT_RST;
    logic [15:0] cfg_last    = osm_pkg::LAST_SLOT_RST;
    logic [7:0]  cfg_timeout = osm_pkg::TIMEOUT_RST;

    // shadow of the tracker state
    logic [osm_pkg::SLOT_COUNT-1:0] latched       = '0;
    logic [osm_pkg::SLOT_COUNT-1:0] sticky        = '0;
    logic [osm_pkg::SLOT_COUNT-1:0] held          = '0;
    logic [osm_pkg::POS_MASK_W-1:0] pos_mask      = '0;
    logic [7:0]                     tick_cnt      = '0;
    logic [15:0]                    prev_code     = '0;
    bit                             cancel_req    = 1'b0;
    bit                             cancel_sticky = 1'b0;

    // results of the item being worked out, then the ones still owed by the block
    key_result_t step_results[$];
    key_result_t owed_results[$];
    key_result_t head;

    // random key pool
    logic [15:0] pool_code[POOL_KEYS];
    logic [7:0]  pool_row[POOL_KEYS];
    logic [7:0]  pool_col[POOL_KEYS];
    bit          pool_down[POOL_KEYS];

    one_shot_modifier_tracker_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_key_code      (s_key_code),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_now_down      (s_now_down),
        .s_was_down      (s_was_down),
        .s_injected      (s_injected),
        .s_with_stickies (s_with_stickies),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_slot          (m_slot),
        .m_active        (m_active),
        .m_last          (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, owed_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold-off counter, owned by this process alone
    always @(posedge aclk) begin
        stall_seen <= stall_flip;
        if (stall_flip != stall_seen) begin
            stall_left <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // result side ready, random idling unless held off
    always @(posedge aclk) begin
        m_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare every result transfer with the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("cycle %0d: unexpected result kind %0d slot %0d active %0b last %0b",
                             cycle_count, m_kind, m_slot, m_active, m_last);
                end
            end else begin
                head = owed_results.pop_front();
                if (m_kind !== head.kind || m_slot !== head.slot ||
                    m_active !== head.active || m_last !== head.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"cycle %0d: want kind %0d slot %0d active %0b last %0b,",
                                  " got kind %0d slot %0d active %0b last %0b"},
                                 cycle_count, head.kind, head.slot, head.active, head.is_last,
                                 m_kind, m_slot, m_active, m_last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tracker prediction
    // ------------------------------------------------------------------

    function automatic void add_result(input osm_pkg::kind_t kind, input int slot);
        key_result_t r;
        r.kind    = kind;
        r.slot    = osm_pkg::SLOT_W'(slot);
        r.active  = 1'b0;
        r.is_last = 1'b0;
        step_results.push_back(r);
    endfunction

    // mask bit of a matrix position, none when out of the matrix
    function automatic bit position_bit(input logic [7:0] row, input logic [7:0] col,
                                        output logic [osm_pkg::POS_MASK_W-1:0] pb);
        int b;
        pb = '0;
        if (row >= osm_pkg::MATRIX_ROWS || col >= osm_pkg::MATRIX_COLS) return 1'b0;
        b = ((int'(row) * 8 + int'(col[2:0])) % 32) + (col >= 8 ? 32 : 0);
        pb = osm_pkg::POS_MASK_W'(1) << b;
        return 1'b1;
    endfunction

    function automatic void track_key(input key_item_t it);
        bit                             on;
        bit                             off;
        bit                             is_slot;
        bit                             has_pos;
        int                             idx;
        logic [osm_pkg::SLOT_COUNT-1:0] sb;
        logic [osm_pkg::POS_MASK_W-1:0] pb;
        on  = it.now_down && !it.was_down;
        off = it.was_down && !it.now_down;
        // synthesized events go straight through
        if (it.injected) begin
            add_result(osm_pkg::KIND_PASS, 0);
            return;
        end
        is_slot = it.key_code >= cfg_first && it.key_code <= cfg_last &&
                  (int'(it.key_code) - int'(cfg_first)) < osm_pkg::SLOT_COUNT;
        idx = is_slot ? int'(it.key_code) - int'(cfg_first) : 0;
        sb  = osm_pkg::SLOT_ONE << idx;
        has_pos = position_bit(it.row, it.col, pb);

        if (latched == '0) begin
            if (!is_slot) begin
                // masked position: swallow, unmask on release
                if (has_pos && (pos_mask & pb) != '0) begin
                    if (off) pos_mask &= ~pb;
                    add_result(osm_pkg::KIND_SUPPRESS, 0);
                end else begin
                    add_result(osm_pkg::KIND_PASS, 0);
                end
                return;
            end
            if (off) begin
                held &= ~sb;
            end else if (on) begin
                tick_cnt  = '0;
                held     |= sb;
                latched  |= sb;
                prev_code = it.key_code;
                add_result(osm_pkg::KIND_PRESS, idx);
            end
            add_result(osm_pkg::KIND_SUPPRESS, 0);
            return;
        end

        // no toggle while something is latched
        if (!it.now_down && !it.was_down) begin
            add_result(osm_pkg::KIND_PASS, 0);
            return;
        end

        if (is_slot) begin
            if ((sticky & sb) != '0) begin
                // tap on a sticky slot lets it go
                if (on) begin
                    prev_code = it.key_code;
                    sticky   &= ~sb;
                    latched  &= ~sb;
                    add_result(osm_pkg::KIND_RELEASE, idx);
                end
            end else begin
                if (off) begin
                    held &= ~sb;
                    if (tick_cnt >= cfg_timeout) begin
                        latched &= ~sb;
                        add_result(osm_pkg::KIND_RELEASE, idx);
                    end
                end
                if (on) begin
                    held |= sb;
                    if (it.key_code == prev_code) begin
                        sticky |= sb;
                    end else begin
                        tick_cnt  = '0;
                        latched  |= sb;
                        prev_code = it.key_code;
                        add_result(osm_pkg::KIND_PRESS, idx);
                    end
                end
            end
            add_result(osm_pkg::KIND_SUPPRESS, 0);
            return;
        end

        // plain key interrupting a latched slot
        if (it.now_down) begin
            if (has_pos) pos_mask |= pb;
            prev_code  = it.key_code;
            cancel_req = 1'b1;
        end
        add_result(osm_pkg::KIND_PASS, 0);
    endfunction

    function automatic void track_tick_after();
        if (latched == '0) return;
        if (tick_cnt < cfg_timeout) tick_cnt++;
        // timeout cancels but spares sticky slots
        if (tick_cnt >= cfg_timeout) begin
            cancel_req    = 1'b1;
            cancel_sticky = 1'b0;
        end
        if (!cancel_req) return;
        for (int i = 0; i < osm_pkg::SLOT_COUNT; i++) begin
            if (sticky[i]) begin
                if (cancel_sticky) begin
                    tick_cnt  = '0;
                    sticky[i] = 1'b0;
                end
            end else if (latched[i] && !held[i]) begin
                tick_cnt   = '0;
                latched[i] = 1'b0;
                add_result(osm_pkg::KIND_RELEASE, i);
            end
        end
        cancel_req    = 1'b0;
        cancel_sticky = 1'b0;
    endfunction

    // work out what one accepted item causes and queue it
    function automatic void track_item(input key_item_t it);
        bit          act;
        key_result_t r;
        step_results.delete();
        case (it.cmd)
            osm_pkg::CMD_KEY: begin
                track_key(it);
            end
            osm_pkg::CMD_TICK_BEFORE: begin
                if (latched != '0) begin
                    for (int i = 0; i < osm_pkg::MODIFIER_SLOTS; i++) begin
                        if (latched[i]) add_result(osm_pkg::KIND_PRESS, i);
                    end
                end
            end
            osm_pkg::CMD_TICK_AFTER: begin
                track_tick_after();
            end
            default: begin
                cancel_req    = 1'b1;
                cancel_sticky = it.with_stickies;
            end
        endcase
        // active reflects the state after the whole item
        act = latched != '0 && tick_cnt < cfg_timeout;
        foreach (step_results[k]) begin
            r         = step_results[k];
            r.active  = act;
            r.is_last = (k == step_results.size() - 1);
            owed_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic key_item_t key_ev(input logic [15:0] code, input logic [7:0] row,
                                         input logic [7:0] col, input bit now_d, input bit was_d);
        key_item_t it;
        it          = '0;
        it.cmd      = osm_pkg::CMD_KEY;
        it.key_code = code;
        it.row      = row;
        it.col      = col;
        it.now_down = now_d;
        it.was_down = was_d;
        return it;
    endfunction

    function automatic key_item_t tick_cmd(input osm_pkg::cmd_t cmd, input bit stickies);
        key_item_t it;
        it               = '0;
        it.cmd           = cmd;
        it.with_stickies = stickies;
        return it;
    endfunction

    // new code and position for a pool key; low half aims at slot codes
    function automatic void refresh_key(input int k);
        int span;
        pool_down[k] = 1'b0;
        pool_row[k]  = ($urandom_range(9) == 0) ? 8'($urandom) :
                                                  8'($urandom_range(osm_pkg::MATRIX_ROWS - 1));
        pool_col[k]  = ($urandom_range(9) == 0) ? 8'($urandom) :
                                                  8'($urandom_range(osm_pkg::MATRIX_COLS - 1));
        span = int'(cfg_last) - int'(cfg_first);
        if (k >= POOL_KEYS / 2 || span < 0) begin
            pool_code[k] = 16'($urandom);
        end else if (span >= osm_pkg::SLOT_COUNT && $urandom_range(7) == 0) begin
            // just past the last real slot
            pool_code[k] = cfg_first + 16'(osm_pkg::SLOT_COUNT);
        end else begin
            pool_code[k] = cfg_first +
                           16'($urandom_range(span < osm_pkg::SLOT_COUNT ? span :
                                                                           osm_pkg::SLOT_COUNT - 1));
        end
    endfunction

    // mostly press/release sequences of pool keys, some ticks, some noise
    function automatic key_item_t random_item();
        key_item_t it;
        int        r;
        int        k;
        it.cmd           = osm_pkg::cmd_t'($urandom_range(3));
        it.key_code      = 16'($urandom);
        it.row           = 8'($urandom);
        it.col           = 8'($urandom);
        it.now_down      = 1'($urandom);
        it.was_down      = 1'($urandom);
        it.injected      = 1'($urandom);
        it.with_stickies = 1'($urandom);
        r = $urandom_range(99);
        if (r < 12) return it;
        if (r < 62) begin
            k           = $urandom_range(POOL_KEYS - 1);
            it.cmd      = osm_pkg::CMD_KEY;
            it.key_code = pool_code[k];
            it.row      = pool_row[k];
            it.col      = pool_col[k];
            it.injected = ($urandom_range(19) == 0);
            if ($urandom_range(9) < 8) begin
                it.now_down  = !pool_down[k];
                it.was_down  = pool_down[k];
                pool_down[k] = !pool_down[k];
                if (!pool_down[k] && $urandom_range(1) == 1) refresh_key(k);
            end else begin
                it.now_down = pool_down[k];
                it.was_down = pool_down[k];
            end
            return it;
        end
        it.cmd = (r < 80) ? osm_pkg::CMD_TICK_AFTER :
                 (r < 90) ? osm_pkg::CMD_TICK_BEFORE : osm_pkg::CMD_CANCEL;
        return it;
    endfunction

    // offer one item, hold it until accepted, then predict it
    task automatic send_item(input key_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= it.cmd;
        s_key_code      <= it.key_code;
        s_row           <= it.row;
        s_col           <= it.col;
        s_now_down      <= it.now_down;
        s_was_down      <= it.was_down;
        s_injected      <= it.injected;
        s_with_stickies <= it.with_stickies;
        do @(posedge aclk); while (!s_ready);
        track_item(it);
    endtask

    // drop valid, wait for every owed result, then let any silent scan finish
    task automatic settle();
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        // setup phase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        // access phase
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            osm_pkg::REG_FIRST_SLOT: cfg_first   = value[15:0];
            osm_pkg::REG_LAST_SLOT:  cfg_last    = value[15:0];
            osm_pkg::REG_TIMEOUT:    cfg_timeout = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] first, input logic [15:0] last_code,
                              input logic [7:0] timeout);
        settle();
        write_reg(osm_pkg::REG_FIRST_SLOT, 32'(first));
        write_reg(osm_pkg::REG_LAST_SLOT, 32'(last_code));
        write_reg(osm_pkg::REG_TIMEOUT, 32'(timeout));
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < POOL_KEYS; k++) refresh_key(k);
        repeat (count) send_item(random_item());
        settle();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pass-through, latching, masking and cancel with the reset settings
    task automatic test_latch_and_masking();
        key_item_t it;
        it = key_ev(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
        it.injected = 1'b1;
        send_item(it);                                           // synthesized event
        send_item(key_ev(16'h0040, 8'd0, 8'd0, 1'b1, 1'b0));    // plain press, nothing latched
        send_item(key_ev(16'd0, 8'd0, 8'd0, 1'b1, 1'b0));       // latch slot zero
        send_item(tick_cmd(osm_pkg::CMD_TICK_BEFORE, 1'b0));     // modifier re-press
        send_item(key_ev(16'h0041, 8'd3, 8'd15, 1'b1, 1'b0));   // interrupt, masks corner
        send_item(key_ev(16'h0042, 8'd4, 8'd16, 1'b1, 1'b0));   // off the matrix
        send_item(key_ev(16'h0041, 8'd3, 8'd15, 1'b0, 1'b1));   // masked release passes
        send_item(tick_cmd(osm_pkg::CMD_TICK_AFTER, 1'b0));      // slot still held
        send_item(key_ev(16'd0, 8'd0, 8'd0, 1'b0, 1'b1));       // let go before timeout
        send_item(tick_cmd(osm_pkg::CMD_CANCEL, 1'b0));
        send_item(tick_cmd(osm_pkg::CMD_TICK_AFTER, 1'b0));      // releases slot zero
        send_item(key_ev(16'h0041, 8'd3, 8'd15, 1'b1, 1'b1));   // masked, swallowed
        send_item(key_ev(16'h0041, 8'd3, 8'd15, 1'b0, 1'b1));   // release unmasks
    endtask

    // repeated taps, sticky release and cancel that clears stickies
    task automatic test_sticky_taps();
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b0, 1'b0));      // slot code, no toggle
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b1, 1'b0));      // latch top slot
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b0, 1'b1));
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b1, 1'b0));      // second tap: sticky
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b0, 1'b0));      // no toggle while latched
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b0, 1'b1));
        send_item(key_ev(16'd31, 8'd1, 8'd9, 1'b1, 1'b0));      // tap on sticky lets go
        send_item(key_ev(16'd5, 8'd2, 8'd4, 1'b1, 1'b0));
        send_item(key_ev(16'd5, 8'd2, 8'd4, 1'b0, 1'b1));
        send_item(key_ev(16'd5, 8'd2, 8'd4, 1'b1, 1'b0));       // sticky modifier
        send_item(tick_cmd(osm_pkg::CMD_CANCEL, 1'b1));
        send_item(tick_cmd(osm_pkg::CMD_TICK_AFTER, 1'b0));      // stickies cleared
    endtask

    // timeout of one tick: release after timeout drops the slot at once
    task automatic test_timeout();
        set_config(16'd0, 16'd31, 8'd1);
        send_item(key_ev(16'd2, 8'd0, 8'd2, 1'b1, 1'b0));
        send_item(tick_cmd(osm_pkg::CMD_TICK_AFTER, 1'b0));
        send_item(key_ev(16'd2, 8'd0, 8'd2, 1'b0, 1'b1));
        send_item(tick_cmd(osm_pkg::CMD_TICK_AFTER, 1'b0));
    endtask

    task automatic test_random(input logic [15:0] first, input logic [15:0] last_code,
                               input logic [7:0] timeout, input int count);
        set_config(first, last_code, timeout);
        run_random(count);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        set_config(16'd0, 16'd31, 8'd5);
        stall_flip <= ~stall_flip;
        run_random(40);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles a little, receiver a lot
        send_idle_pct = 30;
        recv_idle_pct = 85;
        test_latch_and_masking();
        test_sticky_taps();
        test_timeout();
        test_random(16'd0, 16'd31, 8'd40, 40);

        // the other way round
        send_idle_pct = 85;
        recv_idle_pct = 30;
        test_random(16'hFFE0, 16'hFFFF, 8'd3, 60);
        test_random(16'h1000, 16'hFFFF, 8'd255, 50);

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(16'd100, 16'd0, 8'd0, 20);
        test_random(16'hFFFF, 16'hFFFF, 8'd2, 20);
        test_backpressure();

        settle();
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
